[hdl/bpsm_pkg.sv]
// Shared types and codes for the battery power state machine.
`timescale 1ns / 1ps
package bpsm_pkg;

	// Power states, numbered as reported on power_state.
	typedef enum logic [2:0] {
		PS_UNKNOWN  = 3'd0,
		PS_NORMAL   = 3'd1,
		PS_LOW      = 3'd2,
		PS_CRITICAL = 3'd3,
		PS_CHARGING = 3'd4,
		PS_CHARGED  = 3'd5,
		PS_EXT_IDLE = 3'd6,
		PS_FAULT    = 3'd7
	} pwr_state_t;

	// Word kinds on the input channel.
	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_USB    = 2'd1;
	localparam logic [1:0] MODE_STEP   = 2'd2;

	// Charger status codes used by the rules.
	localparam logic [2:0] CHG_UNAVAILABLE   = 3'd1;
	localparam logic [2:0] CHG_LATCHED_FAULT = 3'd3;
	localparam logic [2:0] CHG_CHARGING      = 3'd4;
	localparam logic [2:0] CHG_UNMONITORED   = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] CFG_REFRESH_MIN = 3'd0;
	localparam logic [2:0] CFG_CRITICAL    = 3'd1;
	localparam logic [2:0] CFG_HYSTERESIS  = 3'd2;
	localparam logic [2:0] CFG_FULL        = 3'd3;
	localparam logic [2:0] CFG_FLOOR       = 3'd4;
	localparam logic [2:0] CFG_DEADBAND    = 3'd5;
	localparam logic [2:0] CFG_WINDOW      = 3'd6;

	typedef struct packed {
		logic [15:0] refresh_min_mv;
		logic [15:0] critical_mv;
		logic [15:0] hysteresis_mv;
		logic [15:0] full_mv;
		logic [15:0] plausible_floor_mv;
		logic [15:0] publish_deadband_mv;
		logic [31:0] charge_window_ms;
	} bpsm_cfg_t;

	typedef struct packed {
		pwr_state_t  cur;
		logic [15:0] stored_mv;
		logic        stored_usb;
		logic        have_meas;
		logic        on_ext;
		logic        win_active;
		logic [31:0] deadline_ms;
		logic        has_pub;
		logic [15:0] last_mv;
		logic [2:0]  last_chg;
	} bpsm_state_t;

	// Outcome of one step word.
	typedef struct packed {
		pwr_state_t  next;
		logic        changed;
		logic        pub;
		logic        opened;
		logic        closed;
		logic        on_ext;
		logic        win_active;
		logic [31:0] deadline_ms;
	} bpsm_step_t;

endpackage

[hdl/bpsm_eval.sv]
// Transition, charge window and report decision for one step word.
`timescale 1ns / 1ps
module bpsm_eval import bpsm_pkg::*; (
	input  bpsm_cfg_t   cfg,
	input  bpsm_state_t st,
	input  logic [2:0]  chg,
	input  logic [31:0] now_ms,
	output bpsm_step_t  step
);

	pwr_state_t  plug_tgt;
	pwr_state_t  ext_next;
	pwr_state_t  nxt;
	logic        plaus;
	logic        cur_ext;
	logic        nxt_ext;
	logic        exp_close;
	logic        win_left;
	logic [16:0] refresh_up;
	logic [16:0] critical_up;
	logic [16:0] charged_down;
	logic [15:0] mv_diff;

	always_comb begin
		if (chg <= CHG_UNAVAILABLE) begin
			plug_tgt = PS_EXT_IDLE;
		end else if (chg <= CHG_LATCHED_FAULT) begin
			plug_tgt = PS_FAULT;
		end else begin
			plug_tgt = PS_CHARGING;
		end
	end

	assign plaus        = st.stored_mv >= cfg.plausible_floor_mv;
	assign refresh_up   = {1'b0, cfg.refresh_min_mv} + {1'b0, cfg.hysteresis_mv};
	assign critical_up  = {1'b0, cfg.critical_mv} + {1'b0, cfg.hysteresis_mv};
	assign charged_down = {1'b0, st.stored_mv} + {1'b0, cfg.hysteresis_mv};
	assign cur_ext      = st.cur inside {PS_CHARGING, PS_CHARGED, PS_EXT_IDLE, PS_FAULT};

	// window expiry only checked while plugged in an external state
	assign exp_close = cur_ext && st.stored_usb && st.win_active && (now_ms >= st.deadline_ms);
	assign win_left  = st.win_active && !exp_close;

	// shared external-power rule
	always_comb begin
		ext_next = st.cur;
		if (!st.stored_usb) begin
			ext_next = PS_UNKNOWN;
		end else if (plug_tgt == PS_EXT_IDLE && st.cur != PS_EXT_IDLE) begin
			ext_next = PS_EXT_IDLE;
		end else if (plug_tgt == PS_FAULT && st.cur != PS_FAULT) begin
			ext_next = PS_FAULT;
		end else if (plug_tgt == PS_CHARGING && (st.cur == PS_EXT_IDLE || st.cur == PS_FAULT ||
				(chg == CHG_CHARGING && st.cur == PS_CHARGED))) begin
			ext_next = PS_CHARGING;
		end
	end

	always_comb begin
		nxt = st.cur;
		case (st.cur)
			PS_UNKNOWN: begin
				if (st.stored_usb) nxt = plug_tgt;
				else if (st.have_meas && plaus) nxt = PS_NORMAL;
			end
			PS_NORMAL: begin
				if (st.stored_usb) nxt = plug_tgt;
				else if (!plaus) nxt = PS_UNKNOWN;
				else if (st.stored_mv < cfg.refresh_min_mv) nxt = PS_LOW;
			end
			PS_LOW: begin
				if (st.stored_usb) nxt = plug_tgt;
				else if (!plaus) nxt = PS_UNKNOWN;
				else if (st.stored_mv < cfg.critical_mv) nxt = PS_CRITICAL;
				else if ({1'b0, st.stored_mv} >= refresh_up) nxt = PS_NORMAL;
			end
			PS_CRITICAL: begin
				if (st.stored_usb) nxt = plug_tgt;
				else if (!plaus) nxt = PS_UNKNOWN;
				else if ({1'b0, st.stored_mv} >= critical_up) nxt = PS_LOW;
			end
			PS_CHARGING: begin
				nxt = ext_next;
				if (ext_next == st.cur && chg == CHG_UNMONITORED &&
						st.stored_mv >= cfg.full_mv) nxt = PS_CHARGED;
			end
			PS_CHARGED: begin
				nxt = ext_next;
				if (ext_next == st.cur && charged_down <= {1'b0, cfg.full_mv}) nxt = PS_CHARGING;
			end
			default: begin
				nxt = ext_next;
			end
		endcase
	end

	assign nxt_ext = nxt inside {PS_CHARGING, PS_CHARGED, PS_EXT_IDLE, PS_FAULT};
	assign mv_diff = (st.stored_mv >= st.last_mv) ? (st.stored_mv - st.last_mv)
		: (st.last_mv - st.stored_mv);

	always_comb begin
		step.next        = nxt;
		step.changed     = nxt != st.cur;
		step.opened      = 1'b0;
		step.closed      = exp_close;
		step.on_ext      = st.on_ext;
		step.win_active  = win_left;
		step.deadline_ms = st.deadline_ms;
		if (step.changed) begin
			if (nxt_ext && !st.on_ext) begin
				step.on_ext      = 1'b1;
				step.win_active  = 1'b1;
				step.deadline_ms = now_ms + cfg.charge_window_ms;
				step.opened      = 1'b1;
			end else if (!nxt_ext && st.on_ext) begin
				step.on_ext     = 1'b0;
				step.win_active = 1'b0;
				if (win_left) step.closed = 1'b1;
			end
		end
		// zero deadband reports on every repeat step
		step.pub = step.changed || !st.has_pub || (st.last_chg != chg) ||
			(mv_diff >= cfg.publish_deadband_mv);
	end

endmodule

[hdl/battery_power_state_machine.sv]
// Battery power manager top level: input stage, state, configuration and result register.
`timescale 1ns / 1ps
// Eight-state battery power manager (unknown, normal, low, critical, charging,
// charged, external idle, charge fault). Input words carry a mode: a sample word
// stores voltage and USB presence, a USB word stores presence only, and a step
// word applies the transition rules with its charger status and time, producing
// exactly one result word; sample and USB words produce none. On battery, falling
// voltage thresholds and the floor act at once, rising out of low or critical needs
// the hysteresis margin, and from charged back to charging a fall needs the margin.
// Entering an external power state opens a charge window (deadline = time +
// window, wrapping at 32 bits) which closes on expiry or on leaving external power.
// A report is flagged on every state change, on a charger change, on the first
// step, or when the stored voltage has moved by the deadband since the last report.
// The input stage takes one word per cycle unless a step word waits for the result
// register; a word is registered in the input stage, evaluated combinationally and,
// for a step, stored in the result register. The stage keeps accepting while a
// result waits unless the stalled word is a step. Configuration writes take effect
// on the next edge, to be made only while the block is idle; nothing enforces it.
module battery_power_state_machine import bpsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] voltage_mv,
	input  logic        usb_present,
	input  logic [2:0]  charger_status,
	input  logic [31:0] time_ms,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  power_state,
	output logic        state_changed,
	output logic        publish,
	output logic [15:0] report_mv,
	output logic        report_usb,
	output logic [2:0]  report_charger,
	output logic        window_opened,
	output logic        window_closed,
	output logic        refresh_ok
);

	bpsm_cfg_t   cfg_q;
	bpsm_state_t st_q;
	bpsm_step_t  step;

	// input stage
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [15:0] mv_s1;
	logic        usb_s1;
	logic [2:0]  chg_s1;
	logic [31:0] time_s1;

	// result register
	logic        out_valid_q;
	pwr_state_t  state_q;
	logic        changed_q;
	logic        pub_q;
	logic [15:0] rep_mv_q;
	logic        rep_usb_q;
	logic [2:0]  rep_chg_q;
	logic        opened_q;
	logic        closed_q;

	logic advance;
	logic step_fire;

	// a step word needs the result register free; other words always move on
	assign advance   = valid_s1 && ((mode_s1 != MODE_STEP) || !out_valid_q || out_ready);
	assign step_fire = advance && (mode_s1 == MODE_STEP);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.refresh_min_mv      <= 16'd3500;
			cfg_q.critical_mv         <= 16'd3300;
			cfg_q.hysteresis_mv       <= 16'd100;
			cfg_q.full_mv             <= 16'd4150;
			cfg_q.plausible_floor_mv  <= 16'd2500;
			cfg_q.publish_deadband_mv <= 16'd50;
			cfg_q.charge_window_ms    <= 32'd60000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REFRESH_MIN: cfg_q.refresh_min_mv      <= cfg_data[15:0];
				CFG_CRITICAL:    cfg_q.critical_mv         <= cfg_data[15:0];
				CFG_HYSTERESIS:  cfg_q.hysteresis_mv       <= cfg_data[15:0];
				CFG_FULL:        cfg_q.full_mv             <= cfg_data[15:0];
				CFG_FLOOR:       cfg_q.plausible_floor_mv  <= cfg_data[15:0];
				CFG_DEADBAND:    cfg_q.publish_deadband_mv <= cfg_data[15:0];
				CFG_WINDOW:      cfg_q.charge_window_ms    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			mv_s1   <= voltage_mv;
			usb_s1  <= usb_present;
			chg_s1  <= charger_status;
			time_s1 <= time_ms;
		end
	end

	bpsm_eval u_eval (
		.cfg    (cfg_q),
		.st     (st_q),
		.chg    (chg_s1),
		.now_ms (time_s1),
		.step   (step)
	);

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			case (mode_s1)
				MODE_SAMPLE: begin
					st_q.stored_mv  <= mv_s1;
					st_q.stored_usb <= usb_s1;
					st_q.have_meas  <= 1'b1;
				end
				MODE_USB: begin
					st_q.stored_usb <= usb_s1;
				end
				MODE_STEP: begin
					st_q.cur         <= step.next;
					st_q.on_ext      <= step.on_ext;
					st_q.win_active  <= step.win_active;
					st_q.deadline_ms <= step.deadline_ms;
					if (step.pub) begin
						st_q.has_pub  <= 1'b1;
						st_q.last_mv  <= st_q.stored_mv;
						st_q.last_chg <= chg_s1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			state_q   <= step.next;
			changed_q <= step.changed;
			pub_q     <= step.pub;
			rep_mv_q  <= st_q.stored_mv;
			rep_usb_q <= st_q.stored_usb;
			rep_chg_q <= chg_s1;
			opened_q  <= step.opened;
			closed_q  <= step.closed;
		end
	end

	assign out_valid      = out_valid_q;
	assign power_state    = state_q;
	assign state_changed  = changed_q;
	assign publish        = pub_q;
	assign report_mv      = rep_mv_q;
	assign report_usb     = rep_usb_q;
	assign report_charger = rep_chg_q;
	assign window_opened  = opened_q;
	assign window_closed  = closed_q;
	assign refresh_ok     = !(state_q == PS_LOW || state_q == PS_CRITICAL);

	// external-power flag tracks the state class
	a_ext_flag: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.on_ext == (st_q.cur == PS_CHARGING || st_q.cur == PS_CHARGED ||
			st_q.cur == PS_EXT_IDLE || st_q.cur == PS_FAULT))
		else $error("external flag out of step with state");

	// an open window only exists on external power
	a_win_ext: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.win_active |-> st_q.on_ext)
		else $error("charge window open off external power");

	// a window opens only on a transition, and the transition always reports
	a_open_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && opened_q |-> changed_q && publish && !closed_q)
		else $error("window opened without a state change");

	// a step word taken into the result register shows up next cycle
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |=> out_valid_q && state_q == $past(step.next))
		else $error("step result not registered");

endmodule
